/* hw/rtl/sgsc_pkg.sv */
// Shared types and constants for the sequential gear shift controller.
package sgsc_pkg;

	localparam int unsigned GEAR_W = 4;
	localparam int unsigned POS_W  = 12;
	localparam int unsigned TOL_W  = 8;
	localparam int unsigned TMO_W  = 16;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		OP_STEP = 2'd0,
		OP_UP   = 2'd1,
		OP_DOWN = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		DRV_STOP = 2'd0,
		DRV_FWD  = 2'd1,
		DRV_REV  = 2'd2
	} drive_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIMEOUT   = 3'd0,
		REG_TOLERANCE = 3'd1,
		REG_REST      = 3'd2,
		REG_NEUTRAL   = 3'd3,
		REG_UPSHIFT   = 3'd4,
		REG_DOWNSHIFT = 3'd5,
		REG_TOP_GEAR  = 3'd6
	} cfg_idx_t;

	localparam logic [TMO_W-1:0]  TIMEOUT_RST   = 16'd500;
	localparam logic [TOL_W-1:0]  TOLERANCE_RST = 8'd10;
	localparam logic [POS_W-1:0]  REST_RST      = 12'd2048;
	localparam logic [POS_W-1:0]  NEUTRAL_RST   = 12'd1024;
	localparam logic [POS_W-1:0]  UPSHIFT_RST   = 12'd3072;
	localparam logic [POS_W-1:0]  DOWNSHIFT_RST = 12'd512;
	localparam logic [GEAR_W-1:0] TOP_GEAR_RST  = 4'd6;

	typedef struct packed {
		logic [TMO_W-1:0]  timeout_ms;
		logic [TOL_W-1:0]  tolerance;
		logic [POS_W-1:0]  rest_position;
		logic [POS_W-1:0]  neutral_position;
		logic [POS_W-1:0]  upshift_position;
		logic [POS_W-1:0]  downshift_position;
		logic [GEAR_W-1:0] top_gear;
	} cfg_regs_t;

	typedef struct packed {
		logic [GEAR_W-1:0] cur_gear;
		logic [GEAR_W-1:0] tgt_gear;
		logic [TIME_W-1:0] down_time;
		drive_t            drive;
		logic              cut;
	} ctrl_state_t;

	typedef struct packed {
		drive_t            drive;
		logic              cut;
		logic [GEAR_W-1:0] gear;
		logic [GEAR_W-1:0] req_gear;
		logic              changed;
		logic              failed;
	} result_t;

endpackage

/* hw/rtl/sgsc_item_if.sv */
// Input item channel: operation, feedback sample and time stamp.
interface sgsc_item_if;
	import sgsc_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          operation;
	logic [POS_W-1:0]    feedback;
	logic [TIME_W-1:0]   now_ms;

	modport source (output valid, operation, feedback, now_ms, input ready);
	modport sink   (input valid, operation, feedback, now_ms, output ready);
endinterface

/* hw/rtl/sgsc_result_if.sv */
// Result channel: actuator command, ignition cut, gears and event flags.
interface sgsc_result_if;
	import sgsc_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          drive;
	logic                spark_cut;
	logic [GEAR_W-1:0]   gear;
	logic [GEAR_W-1:0]   requested_gear;
	logic                gear_changed;
	logic                shift_failed;

	modport source (output valid, drive, spark_cut, gear, requested_gear, gear_changed,
		shift_failed, input ready);
	modport sink   (input valid, drive, spark_cut, gear, requested_gear, gear_changed,
		shift_failed, output ready);
endinterface

/* hw/rtl/sgsc_cfg_if.sv */
// Configuration write channel: register index and write data.
interface sgsc_cfg_if;
	import sgsc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/sgsc_step.sv */
// Next-state and result logic for one input item.
module sgsc_step import sgsc_pkg::*; (
	input  cfg_regs_t         cfg,
	input  ctrl_state_t       st,
	input  logic [1:0]        operation,
	input  logic [POS_W-1:0]  feedback,
	input  logic [TIME_W-1:0] now_ms,
	output ctrl_state_t       nxt,
	output result_t           res
);

	logic [POS_W:0]    fb_ext;
	logic [POS_W:0]    tol_ext;
	logic [TIME_W-1:0] elapsed;
	logic              timed_out;
	logic              near_rest;
	logic              near_goal;
	logic [POS_W-1:0]  up_goal;
	logic [POS_W-1:0]  down_goal;
	logic [POS_W-1:0]  goal;
	logic              going_up;
	logic              changed;
	logic              failed;
	drive_t            rest_drive;

	// Strict window: target - tol < fb < target + tol, no overflow at 13 bits.
	function automatic logic in_window(input logic [POS_W:0] f, input logic [POS_W:0] e,
		input logic [POS_W-1:0] t);
		logic [POS_W:0] t_ext;
		t_ext = {1'b0, t};
		return ((f + e) > t_ext) && (f < (t_ext + e));
	endfunction

	always_comb begin
		fb_ext    = {1'b0, feedback};
		tol_ext   = {{(POS_W + 1 - TOL_W){1'b0}}, cfg.tolerance};
		elapsed   = now_ms - st.down_time;
		timed_out = elapsed > {{(TIME_W - TMO_W){1'b0}}, cfg.timeout_ms};
		near_rest = in_window(fb_ext, tol_ext, cfg.rest_position);
		going_up  = st.tgt_gear > st.cur_gear;
		up_goal   = (st.cur_gear == '0) ? cfg.downshift_position : cfg.upshift_position;
		down_goal = (st.cur_gear == GEAR_W'(1)) ? cfg.neutral_position
			: cfg.downshift_position;
		goal      = going_up ? up_goal : down_goal;
		near_goal = in_window(fb_ext, tol_ext, goal);

		priority if (near_rest) begin
			rest_drive = DRV_STOP;
		end else if (feedback < cfg.rest_position) begin
			rest_drive = DRV_REV;
		end else begin
			rest_drive = DRV_FWD;
		end
	end

	always_comb begin
		nxt     = st;
		changed = 1'b0;
		failed  = 1'b0;
		unique case (operation)
			OP_UP: begin
				if (st.tgt_gear < cfg.top_gear) begin
					nxt.tgt_gear = st.tgt_gear + GEAR_W'(1);
				end
			end
			OP_DOWN: begin
				if (st.tgt_gear != '0) begin
					nxt.tgt_gear  = st.tgt_gear - GEAR_W'(1);
					nxt.down_time = now_ms;
				end
			end
			OP_STEP: begin
				if (going_up && (st.cur_gear < cfg.top_gear)) begin
					nxt.cut   = 1'b1;
					nxt.drive = (st.cur_gear == '0) ? DRV_FWD : DRV_REV;
					if (near_goal) begin
						nxt.cur_gear = st.cur_gear + GEAR_W'(1);
						nxt.cut      = 1'b0;
						changed      = 1'b1;
					end
				end else if (!going_up && (st.tgt_gear < st.cur_gear) && !timed_out) begin
					nxt.cut   = 1'b1;
					nxt.drive = (st.cur_gear == GEAR_W'(1)) ? DRV_REV : DRV_FWD;
					if (near_goal) begin
						nxt.cur_gear = st.cur_gear - GEAR_W'(1);
						nxt.cut      = 1'b0;
						changed      = 1'b1;
					end
				end else begin
					// return to rest; a stale downshift is dropped here
					if (!going_up && (st.tgt_gear < st.cur_gear)) begin
						nxt.tgt_gear = st.cur_gear;
						failed       = 1'b1;
					end
					nxt.cut   = 1'b0;
					nxt.drive = rest_drive;
				end
			end
			default: begin
			end
		endcase

		res.drive    = nxt.drive;
		res.cut      = nxt.cut;
		res.gear     = nxt.cur_gear;
		res.req_gear = nxt.tgt_gear;
		res.changed  = changed;
		res.failed   = failed;
	end

endmodule

/* hw/rtl/sequential_gear_shift_controller_unit.sv */
// Sequential gear shift controller: input register, step logic, result register.
// An accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle unless the result stalls; gear state updates once per item.
// Either register stage advances when the next one is empty or being drained.
// Reset: gears, down-press time, drive (stopped) and ignition cut clear; configuration
// registers return to their default values; both pipeline stages are emptied.
module sequential_gear_shift_controller_unit import sgsc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	sgsc_item_if.sink     item,
	sgsc_result_if.source result,
	sgsc_cfg_if.sink      cfg
);

	cfg_regs_t         cfg_q;
	ctrl_state_t       state_q;
	ctrl_state_t       state_nxt;
	result_t           res_nxt;
	result_t           res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic [1:0]        op_s1;
	logic [POS_W-1:0]  fb_s1;
	logic [TIME_W-1:0] now_s1;
	logic              advance;
	logic              take_item;

	assign cfg.ready  = 1'b1;
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign take_item  = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ms         <= TIMEOUT_RST;
			cfg_q.tolerance          <= TOLERANCE_RST;
			cfg_q.rest_position      <= REST_RST;
			cfg_q.neutral_position   <= NEUTRAL_RST;
			cfg_q.upshift_position   <= UPSHIFT_RST;
			cfg_q.downshift_position <= DOWNSHIFT_RST;
			cfg_q.top_gear           <= TOP_GEAR_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_TIMEOUT:   cfg_q.timeout_ms         <= cfg.data;
				REG_TOLERANCE: cfg_q.tolerance          <= cfg.data[TOL_W-1:0];
				REG_REST:      cfg_q.rest_position      <= cfg.data[POS_W-1:0];
				REG_NEUTRAL:   cfg_q.neutral_position   <= cfg.data[POS_W-1:0];
				REG_UPSHIFT:   cfg_q.upshift_position   <= cfg.data[POS_W-1:0];
				REG_DOWNSHIFT: cfg_q.downshift_position <= cfg.data[POS_W-1:0];
				REG_TOP_GEAR:  cfg_q.top_gear           <= cfg.data[GEAR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	sgsc_step u_step (
		.cfg       (cfg_q),
		.st        (state_q),
		.operation (op_s1),
		.feedback  (fb_s1),
		.now_ms    (now_s1),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.cur_gear  <= '0;
			state_q.tgt_gear  <= '0;
			state_q.down_time <= '0;
			state_q.drive     <= DRV_STOP;
			state_q.cut       <= 1'b0;
			valid_s1          <= 1'b0;
			valid_s2          <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload stages: hold unless a transaction moves them
	always_ff @(posedge clk) begin
		if (take_item) begin
			op_s1  <= item.operation;
			fb_s1  <= item.feedback;
			now_s1 <= item.now_ms;
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign result.valid          = valid_s2;
	assign result.drive          = res_s2.drive;
	assign result.spark_cut      = res_s2.cut;
	assign result.gear           = res_s2.gear;
	assign result.requested_gear = res_s2.req_gear;
	assign result.gear_changed   = res_s2.changed;
	assign result.shift_failed   = res_s2.failed;

endmodule
